// File: design/mts_pkg.sv
// Package for the minimum-tracking stack: depth, widths, beat types and codes.
// Used by min_tracking_stack and its testbench; depends on nothing else.
`timescale 1ns / 1ps

package mts_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int ITEM_CNT_W  = 11;

  // Operation codes carried in the mode field.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Control sequencer states.
  typedef enum logic {
    S_IDLE,
    S_POP_WAIT
  } state_e;

  // One input beat.
  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] value;
  } in_t;

  // One result beat.
  typedef struct packed {
    status_e               status;
    logic [DATA_W-1:0]     popped_value;
    logic [DATA_W-1:0]     min_value;
    logic                  min_valid;
    logic [ITEM_CNT_W-1:0] item_count;
  } out_t;

endpackage

// File: design/mts_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; width and depth come from its parameters.
`timescale 1ns / 1ps

module mts_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/min_tracking_stack.sv
// Top level of the minimum-tracking stack: control, top-of-stack registers, result register.
// Depends on mts_pkg and on two instances of mts_ram.
`timescale 1ns / 1ps

// Usage:
// Each input beat on in_data_i is a push (mode 0) or a pop (mode 1); it is
// taken at a rising edge where in_valid_i is high and in_stall_o is low.
// Every input beat yields exactly one result beat on out_data_o, taken at an
// edge where out_valid_o is high and out_stall_i is low.
// A push, a rejected push and a rejected pop give a result that is valid the
// cycle after the input beat is taken. A successful pop passes through
// S_POP_WAIT first, because the new top of the value stack, and of the minima
// stack when its minimum is dropped, must be read from the registered-read memories.
// The block works on one beat at a time; it takes a new beat once the
// previous one is done and the result register is empty or being drained.
// While the receiver stalls, the result register holds its beat and
// in_stall_o stays high.
// Reset clears both counts and the control state; memory contents are not
// cleared and there is no clearing pass, so the block is ready right after
// reset.
module min_tracking_stack (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mts_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mts_pkg::out_t out_data_o
);

  import mts_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    mcnt_q, mcnt_d;
  logic [DATA_W-1:0]   vtop_q, vtop_d;
  logic [DATA_W-1:0]   mtop_q, mtop_d;
  logic [DATA_W-1:0]   pop_val_q, pop_val_d;
  logic                drop_q, drop_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic                accept;
  logic                out_free;
  logic                is_full;
  logic                is_empty;
  logic                take_min;
  logic                drop_min;
  logic [CNT_W-1:0]    cnt_m1, cnt_m2, mcnt_m1, mcnt_m2;

  logic                vram_we, mram_we, vram_re, mram_re;
  logic [ADDR_W-1:0]   vram_waddr, mram_waddr, vram_raddr, mram_raddr;
  logic [DATA_W-1:0]   vram_rdata, mram_rdata;

  // Handshake: one beat in flight, result register must be free or draining.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (cnt_q == CNT_W'(STACK_DEPTH));
  assign is_empty = (cnt_q == '0);
  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign cnt_m2   = cnt_q - CNT_W'(2);
  assign mcnt_m1  = mcnt_q - CNT_W'(1);
  assign mcnt_m2  = mcnt_q - CNT_W'(2);

  // A pushed value joins the minima when none is held or it does not exceed the top.
  assign take_min = (mcnt_q == '0) || (in_data_i.value <= mtop_q);
  // A popped value that equals the minimum takes that minimum with it.
  assign drop_min = (mcnt_q != '0) && (vtop_q == mtop_q);

  // Memory accesses: pushes write at the counts, pops read the entries that become the new tops.
  assign vram_we    = accept && (in_data_i.mode == MODE_PUSH) && !is_full;
  assign mram_we    = vram_we && take_min && (mcnt_q != CNT_W'(STACK_DEPTH));
  assign vram_waddr = cnt_q[ADDR_W-1:0];
  assign mram_waddr = mcnt_q[ADDR_W-1:0];
  assign vram_re    = accept && (in_data_i.mode == MODE_POP) && !is_empty;
  assign mram_re    = vram_re && drop_min;
  assign vram_raddr = cnt_m2[ADDR_W-1:0];
  assign mram_raddr = mcnt_m2[ADDR_W-1:0];

  mts_ram #(
    .Width (DATA_W),
    .Depth (STACK_DEPTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (in_data_i.value),
    .re_i    (vram_re),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  mts_ram #(
    .Width (DATA_W),
    .Depth (STACK_DEPTH)
  ) u_minima_ram (
    .clk_i   (clk_i),
    .we_i    (mram_we),
    .waddr_i (mram_waddr),
    .wdata_i (in_data_i.value),
    .re_i    (mram_re),
    .raddr_i (mram_raddr),
    .rdata_o (mram_rdata)
  );

  // Next state, stack updates and result formation.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mcnt_d      = mcnt_q;
    vtop_d      = vtop_q;
    mtop_d      = mtop_q;
    pop_val_d   = pop_val_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.mode == MODE_PUSH) begin
            out_valid_d         = 1'b1;
            out_d.popped_value  = '0;
            if (is_full) begin
              out_d.status     = ST_FULL;
              out_d.min_valid  = (mcnt_q != '0);
              out_d.min_value  = (mcnt_q != '0) ? mtop_q : '0;
              out_d.item_count = ITEM_CNT_W'(cnt_q);
            end else begin
              cnt_d  = cnt_q + CNT_W'(1);
              vtop_d = in_data_i.value;
              if (mram_we) begin
                mcnt_d = mcnt_q + CNT_W'(1);
                mtop_d = in_data_i.value;
              end
              out_d.status     = ST_DONE;
              out_d.min_valid  = 1'b1;
              out_d.min_value  = mram_we ? in_data_i.value : mtop_q;
              out_d.item_count = ITEM_CNT_W'(cnt_q + CNT_W'(1));
            end
          end else if (is_empty) begin
            out_valid_d        = 1'b1;
            out_d.status       = ST_EMPTY;
            out_d.popped_value = '0;
            out_d.min_value    = '0;
            out_d.min_valid    = 1'b0;
            out_d.item_count   = ITEM_CNT_W'(cnt_q);
          end else begin
            // Successful pop: counts drop now, new tops arrive next cycle.
            pop_val_d = vtop_q;
            drop_d    = drop_min;
            cnt_d     = cnt_m1;
            if (drop_min) begin
              mcnt_d = mcnt_m1;
            end
            state_d = S_POP_WAIT;
          end
        end
      end

      S_POP_WAIT: begin
        vtop_d = vram_rdata;
        if (drop_q) begin
          mtop_d = mram_rdata;
        end
        out_valid_d        = 1'b1;
        out_d.status       = ST_DONE;
        out_d.popped_value = pop_val_q;
        out_d.min_valid    = (cnt_q != '0) && (mcnt_q != '0);
        out_d.min_value    = out_d.min_valid ? (drop_q ? mram_rdata : mtop_q) : '0;
        out_d.item_count   = ITEM_CNT_W'(cnt_q);
        state_d            = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mcnt_q      <= mcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: tops, pending pop value and result.
  always_ff @(posedge clk_i) begin
    vtop_q    <= vtop_d;
    mtop_q    <= mtop_d;
    pop_val_q <= pop_val_d;
    drop_q    <= drop_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: dv/tb_min_tracking_stack.sv
// Self-checking testbench for min_tracking_stack: a directed table, then random push/pop traffic.
// Results are checked against typed rows or an in-bench stack model; depends on mts_pkg and the design only.
`timescale 1ns / 1ps

module tb_min_tracking_stack;
  import mts_pkg::*;

  localparam int RANDOM_ITEMS  = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 8;

  // Per-beat note: a typed result for some directed rows, or none.
  typedef struct {
    bit   known;
    out_t result;
  } beat_note_t;

  typedef struct {
    in_t        beat;
    beat_note_t note;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  min_tracking_stack dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Shadow stacks of values and running minima.
  logic [DATA_W-1:0] vals_mem [STACK_DEPTH];
  logic [DATA_W-1:0] mins_mem [STACK_DEPTH];
  int unsigned       val_depth = 0;
  int unsigned       min_depth = 0;

  out_t       pending_results [$];
  beat_note_t beat_notes [$];
  int         drv_depth = 0;
  bit         quiet_sender = 1'b0;
  bit         held_off = 1'b0;
  int         error_count = 0;
  int         results_seen = 0;
  int         n_push = 0, n_pop = 0, n_full = 0, n_empty = 0, peak_depth = 0;

  // Apply one beat to the shadow stacks and return the result it should produce.
  function automatic out_t stack_apply(input in_t beat);
    out_t              r;
    logic [DATA_W-1:0] top;
    r = '0;
    r.status = ST_DONE;
    if (beat.mode == MODE_PUSH) begin
      if (val_depth >= STACK_DEPTH) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        vals_mem[val_depth] = beat.value;
        val_depth++;
        n_push++;
        // Equal values are recorded too, so duplicate pops keep the minimum right.
        if (min_depth == 0 || beat.value <= mins_mem[min_depth-1]) begin
          if (min_depth < STACK_DEPTH) begin
            mins_mem[min_depth] = beat.value;
            min_depth++;
          end
        end
      end
    end else if (val_depth == 0) begin
      r.status = ST_EMPTY;
      n_empty++;
    end else begin
      val_depth--;
      top = vals_mem[val_depth];
      n_pop++;
      if (min_depth > 0 && top == mins_mem[min_depth-1]) min_depth--;
      r.popped_value = top;
    end
    if (val_depth > 0 && min_depth > 0) begin
      r.min_value = mins_mem[min_depth-1];
      r.min_valid = 1'b1;
    end
    r.item_count = ITEM_CNT_W'(val_depth);
    if (int'(val_depth) > peak_depth) peak_depth = val_depth;
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic mode, input logic [DATA_W-1:0] value,
                                      input bit known, input status_e st,
                                      input logic [DATA_W-1:0] popped,
                                      input logic [DATA_W-1:0] mn, input logic mv,
                                      input logic [ITEM_CNT_W-1:0] cnt);
    dir_row_t row;
    row.beat.mode                = mode;
    row.beat.value               = value;
    row.note.known               = known;
    row.note.result.status       = st;
    row.note.result.popped_value = popped;
    row.note.result.min_value    = mn;
    row.note.result.min_valid    = mv;
    row.note.result.item_count   = cnt;
    return row;
  endfunction

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Small values give many duplicates and minima changes; the rest spans the field.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'($urandom_range(0, 15));
      4:          return '0;
      5:          return '1;
      6:          return 32'hFFFF_FFF0 | DATA_W'($urandom_range(0, 15));
      default:    return DATA_W'($urandom);
    endcase
  endfunction

  task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
    $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
  endtask

  // Offer one beat after a random gap and hold it until the block takes it.
  task automatic send_beat(input in_t beat, input beat_note_t note);
    int gap;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat_notes.push_back(note);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    if (beat.mode == MODE_PUSH && drv_depth < STACK_DEPTH) drv_depth++;
    if (beat.mode == MODE_POP && drv_depth > 0) drv_depth--;
  endtask

  task automatic send_random(input logic mode);
    in_t        beat;
    beat_note_t note;
    beat.mode  = mode;
    beat.value = pick_value();
    note.known = 1'b0;
    note.result = '0;
    send_beat(beat, note);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check each result beat and record what each accepted input beat should produce.
  out_t       want_res, model_res;
  beat_note_t taken_note;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, out_data_o);
          error_count++;
        end else begin
          want_res = pending_results.pop_front();
          if (out_data_o !== want_res) begin
            error_count++;
            if (out_data_o.status !== want_res.status)
              report_field("status", want_res.status, out_data_o.status);
            if (out_data_o.popped_value !== want_res.popped_value)
              report_field("popped_value", want_res.popped_value, out_data_o.popped_value);
            if (out_data_o.min_value !== want_res.min_value)
              report_field("min_value", want_res.min_value, out_data_o.min_value);
            if (out_data_o.min_valid !== want_res.min_valid)
              report_field("min_valid", want_res.min_valid, out_data_o.min_valid);
            if (out_data_o.item_count !== want_res.item_count)
              report_field("item_count", want_res.item_count, out_data_o.item_count);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        taken_note = beat_notes.pop_front();
        model_res  = stack_apply(in_data_i);
        pending_results.push_back(taken_note.known ? taken_note.result : model_res);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input side.
  initial begin : receiver
    int run;
    int gap;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Sender: reset, directed table, random phases, then drain and report.
  initial begin : sender
    dir_row_t dir_rows [$];
    int       sent;
    int       phase;
    int       len;
    int       push_pct;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;

    // Empty pops, extremes, equal minima and duplicate pops; typed where obvious.
    dir_rows.push_back(mk_row(MODE_POP,  32'hDEAD_BEEF, 1, ST_EMPTY, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'hFFFF_FFFF, 1, ST_DONE, 0, 32'hFFFF_FFFF, 1, 1));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'hFFFF_FFFF, 1, ST_DONE, 0, 32'hFFFF_FFFF, 1, 2));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'h0000_0000, 1, ST_DONE, 0, 0, 1, 3));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'h0000_0000, 1, ST_DONE, 0, 0, 1, 4));
    dir_rows.push_back(mk_row(MODE_POP,  32'hFFFF_FFFF, 1, ST_DONE, 0, 0, 1, 3));
    dir_rows.push_back(mk_row(MODE_POP,  32'h1234_5678, 1, ST_DONE, 0, 32'hFFFF_FFFF, 1, 2));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'd5, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'd7, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'd5, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_POP,  32'd0, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_POP,  32'd0, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_POP,  32'd0, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_POP,  32'd0, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_POP,  32'd0, 1, ST_DONE, 32'hFFFF_FFFF, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_POP,  32'hFFFF_FFFF, 1, ST_EMPTY, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'hAAAA_AAAA, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'h5555_5555, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_PUSH, 32'h8000_0000, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_POP,  32'h0000_0001, 0, ST_DONE, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_POP,  32'h7FFF_FFFF, 0, ST_DONE, 0, 0, 0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].note);

    // Random phases with a push bias each; one phase fills past full, the next drains.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet_sender = ($urandom_range(0, 3) == 0);
      if (phase == 4) begin
        while (drv_depth < STACK_DEPTH) begin
          send_random(MODE_PUSH);
          sent++;
        end
        repeat (3) begin
          send_random(MODE_PUSH);
          sent++;
        end
      end else if (phase == 5) begin
        while (drv_depth > 0) begin
          send_random(MODE_POP);
          sent++;
        end
        repeat (2) begin
          send_random(MODE_POP);
          sent++;
        end
      end else begin
        len = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 75;
        endcase
        repeat (len) begin
          send_random(($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP);
          sent++;
        end
      end
      phase++;
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d pushes, %0d full rejects, %0d pops, %0d empty rejects.",
             n_push, n_full, n_pop, n_empty);
    $display("Stack reached depth %0d; %0d result beats checked, %0d errors.",
             peak_depth, results_seen, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/mts_pkg.sv
design/mts_ram.sv
design/min_tracking_stack.sv
dv/tb_min_tracking_stack.sv
